[sv/vwap_candlestick_aggregator_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef VWAP_CANDLESTICK_AGGREGATOR_TOP_DEFINES_SVH
`define VWAP_CANDLESTICK_AGGREGATOR_TOP_DEFINES_SVH

// Implication into the next cycle, ignored while reset is asserted.
`define VCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication into the next cycle that is checked during reset as well.
`define VCA_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[sv/vca_pkg.sv]
package vca_pkg;

    localparam int PRICE_BITS = 32;
    localparam int PRICE_EFF  = (PRICE_BITS < 32) ? PRICE_BITS : 32;
    localparam logic [31:0] PRICE_MASK = 32'((64'd1 << PRICE_EFF) - 64'd1);
    localparam logic [63:0] CLOSE_MAX  = {32'd0, PRICE_MASK};
    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [47:0] order_time;
        logic [15:0] order_product;
        logic [31:0] order_price;
        logic [31:0] order_amount;
        logic        last_order;
    } t_order;

    typedef struct packed {
        logic [47:0] bar_time;
        logic [31:0] open_price;
        logic [31:0] high_price;
        logic [31:0] low_price;
        logic [31:0] close_price;
        logic        final_bar;
    } t_bar;

    // A finished bucket handed from the front end to the divider.
    typedef struct packed {
        logic [47:0] bucket_time;
        logic [63:0] value_sum;
        logic [63:0] amount_sum;
        logic [31:0] bucket_high;
        logic [31:0] bucket_low;
        logic        final_bar;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

endpackage

[sv/vwap_candlestick_aggregator_top.sv]
// VWAP candlestick aggregator. Orders for the product in the configuration register are
// grouped by timestamp; each change of timestamp, and each order marked last, produces one
// bar with open, high, low, volume-weighted close and time. The front end takes one order
// at a time, stalling while busy (a registered 32x32 product, then the accumulate), and a
// last-order flush adds a flush state. Finished buckets wait in a two-word queue for the back
// end, whose bit-serial 64-bit divider runs 64 divide steps, then forms the bar and presents
// it until taken, taking no new bucket meanwhile, so bursts of bars are limited by the
// divider. Beyond its busy states per order, the front end stalls longer only when a bar
// must be queued and the queue is full.
module vwap_candlestick_aggregator_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_wdata,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  vca_pkg::t_order  i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output vca_pkg::t_bar    o_out_word
);
    vca_pkg::t_fifo_ctl w_ctl;
    vca_pkg::t_job      w_push_job, w_pop_job;
    logic               w_full, w_empty;

    vca_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_fifo_full (w_full),
        .o_push      (w_ctl.push),
        .o_job       (w_push_job)
    );

    vca_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_ctl.push),
        .i_data  (w_push_job),
        .i_pop   (w_ctl.pop),
        .o_data  (w_pop_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    vca_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (w_empty),
        .i_job        (w_pop_job),
        .o_pop        (w_ctl.pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word)
    );
endmodule

[sv/vca_fifo.sv]
module vca_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vca_pkg::t_job   i_data,
    input  logic            i_pop,
    output vca_pkg::t_job   o_data,
    output logic            o_full,
    output logic            o_empty
);
    localparam int AW = $clog2(vca_pkg::FIFO_DEPTH);

    vca_pkg::t_job r_mem [vca_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(vca_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= AW'((r_wp + 1'b1) % vca_pkg::FIFO_DEPTH);
            if (i_pop)  r_rp <= AW'((r_rp + 1'b1) % vca_pkg::FIFO_DEPTH);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

[sv/vca_front.sv]
module vca_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  vca_pkg::t_order   i_in_word,
    input  logic              i_fifo_full,
    output logic              o_push,
    output vca_pkg::t_job     o_job
);
    typedef enum logic [2:0] {
        F_IDLE  = 3'b001,
        F_CALC  = 3'b010,
        F_FLUSH = 3'b100
    } t_fstate;

    t_fstate         r_state, n_state;
    vca_pkg::t_order r_item;
    logic [63:0]     r_prod;
    logic [15:0]     r_code;
    logic            r_open, n_open;
    logic [47:0]     r_time, n_time;
    logic [63:0]     r_vsum, n_vsum, r_asum, n_asum;
    logic [31:0]     r_high, n_high, r_low, n_low;
    logic [31:0]     w_price;
    logic            w_match;
    logic [64:0]     w_vadd, w_aadd;

    assign o_in_stall = (r_state != F_IDLE);
    assign w_price    = r_item.order_price & vca_pkg::PRICE_MASK;
    assign w_match    = (r_item.order_product == r_code);
    assign w_vadd     = {1'b0, r_vsum} + {1'b0, r_prod};
    assign w_aadd     = {1'b0, r_asum} + {33'd0, r_item.order_amount};

    always_comb begin
        n_state = r_state;
        n_open  = r_open;
        n_time  = r_time;
        n_vsum  = r_vsum;
        n_asum  = r_asum;
        n_high  = r_high;
        n_low   = r_low;
        o_push  = 1'b0;
        o_job   = '{bucket_time: r_time, value_sum: r_vsum, amount_sum: r_asum,
                    bucket_high: r_high, bucket_low: r_low, final_bar: 1'b0};
        case (r_state)
            F_IDLE: begin
                if (i_in_valid) n_state = F_CALC;
            end
            F_CALC: begin
                if (w_match && r_open && (r_item.order_time != r_time) && i_fifo_full) begin
                    n_state = F_CALC;
                end else begin
                    if (w_match && (!r_open || (r_item.order_time != r_time))) begin
                        o_push = r_open;
                        n_open = 1'b1;
                        n_time = r_item.order_time;
                        n_vsum = r_prod;
                        n_asum = {32'd0, r_item.order_amount};
                        n_high = w_price;
                        n_low  = w_price;
                    end else if (w_match) begin
                        // Sums stick at all ones once they overflow.
                        n_vsum = w_vadd[64] ? '1 : w_vadd[63:0];
                        n_asum = w_aadd[64] ? '1 : w_aadd[63:0];
                        if (w_price > r_high) n_high = w_price;
                        if (w_price < r_low)  n_low  = w_price;
                    end
                    n_state = r_item.last_order ? F_FLUSH : F_IDLE;
                end
            end
            F_FLUSH: begin
                o_job.final_bar = 1'b1;
                if (!(r_open && i_fifo_full)) begin
                    o_push  = r_open;
                    n_open  = 1'b0;
                    n_time  = '0;
                    n_vsum  = '0;
                    n_asum  = '0;
                    n_high  = '0;
                    n_low   = '0;
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && (r_state == F_IDLE)) begin
            r_item <= i_in_word;
            r_prod <= {32'd0, i_in_word.order_price & vca_pkg::PRICE_MASK}
                      * {32'd0, i_in_word.order_amount};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_code  <= '0;
            r_open  <= 1'b0;
            r_time  <= '0;
            r_vsum  <= '0;
            r_asum  <= '0;
            r_high  <= '0;
            r_low   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_code <= i_cfg_wdata;
            r_open  <= n_open;
            r_time  <= n_time;
            r_vsum  <= n_vsum;
            r_asum  <= n_asum;
            r_high  <= n_high;
            r_low   <= n_low;
        end
    end
endmodule

[sv/vca_back.sv]
module vca_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fifo_empty,
    input  vca_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output vca_pkg::t_bar   o_out_word
);
    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_DIV  = 4'b0010,
        B_FIN  = 4'b0100,
        B_WAIT = 4'b1000
    } t_bstate;

    t_bstate       r_state;
    vca_pkg::t_job r_job;
    logic [63:0]   r_rem, r_quo;
    logic [5:0]    r_cnt;
    logic [31:0]   r_prev;
    vca_pkg::t_bar r_out;
    logic [64:0]   w_shift, w_diff;
    logic [31:0]   w_close;

    assign o_pop       = (r_state == B_IDLE) && !i_fifo_empty;
    assign o_out_valid = (r_state == B_WAIT);
    assign o_out_word  = r_out;

    // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
    assign w_shift = {r_rem, r_quo[63]};
    assign w_diff  = w_shift - {1'b0, r_job.amount_sum};

    always_comb begin
        if (r_job.amount_sum == '0) begin
            w_close = '0;
        end else if (r_quo > vca_pkg::CLOSE_MAX) begin
            w_close = vca_pkg::CLOSE_MAX[31:0];
        end else begin
            w_close = r_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
                r_rem <= '0;
                r_quo <= i_job.value_sum;
            end
            B_DIV: begin
                if (!w_diff[64]) begin
                    r_rem <= w_diff[63:0];
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= w_shift[63:0];
                    r_quo <= {r_quo[62:0], 1'b0};
                end
            end
            B_FIN: begin
                r_out <= '{bar_time: r_job.bucket_time, open_price: r_prev,
                           high_price: r_job.bucket_high, low_price: r_job.bucket_low,
                           close_price: w_close, final_bar: r_job.final_bar};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_cnt   <= '0;
            r_prev  <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    r_cnt <= '0;
                    if (!i_fifo_empty) r_state <= B_DIV;
                end
                B_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == '1) r_state <= B_FIN;
                end
                B_FIN: begin
                    // A flush ends the data set, so the next bar opens at zero.
                    r_prev  <= r_job.final_bar ? '0 : w_close;
                    r_state <= B_WAIT;
                end
                B_WAIT: begin
                    if (!i_out_stall) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

[sv/vca_checker.sv]
`include "vwap_candlestick_aggregator_top_defines.svh"

module vca_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input vca_pkg::t_bar   o_out_word
);
    // Once the front end takes an order, it shows itself busy.
    `VCA_ASSERT_NEXT(a_in_busy, i_in_valid && !o_in_stall, o_in_stall, "order taken without busy cycle")
    // A taken word is followed by at least a full divide, never by another word.
    `VCA_ASSERT_NEXT(a_out_gap, o_out_valid && !i_out_stall, !o_out_valid, "bar words back to back")
    `VCA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled bar changed")
    `VCA_ASSERT_NEXT_ALWAYS(a_reset, !i_rst_n, !o_out_valid && !o_in_stall, "not idle after reset")
endmodule

bind vwap_candlestick_aggregator_top vca_checker u_vca_checker (.*);
